>>> hdl/hps_pkg.sv
// Shared constants for the Hamming parity / syndrome block.
// No dependencies; every other file of the block imports this package.
package hps_pkg;

  localparam int BITS_PER_BYTE    = 8;
  localparam int MSG_W            = 8;
  localparam int PARITY_FIELD_W   = 11;
  localparam int COUNT_W          = 4;
  localparam int MAX_BYTES_DEF    = 128;
  localparam int PARITY_WIDTH_DEF = 11;

  // First data position of a codeword (1 and 2 hold parity).
  localparam int FIRST_POS        = 3;

  // Candidate positions a lane scans from the byte's base position. With a
  // base of 3 or more, ten consecutive positions hold at least eight
  // positions that are not powers of two.
  localparam int WINDOW           = 10;
  localparam int WIN_CNT_W        = 4;

  // Largest parity count examined by the length search.
  localparam int COUNT_MAX        = 15;
  localparam int COUNT_CALC_W     = 17;

endpackage

>>> hdl/hps_lane.sv
// One bit lane: finds the codeword position of one data bit of a byte and
// its contribution to the parity word. Depends on hps_pkg.
module hps_lane #(
  parameter int LANE         = 0,
  parameter int POS_W        = 12,
  parameter int PARITY_WIDTH = hps_pkg::PARITY_WIDTH_DEF
) (
  input  logic [POS_W-1:0]        base,
  input  logic                    data_bit,
  output logic [POS_W-1:0]        pos,
  output logic [PARITY_WIDTH-1:0] contrib
);
  import hps_pkg::*;

  logic [POS_W-1:0]     cand [WINDOW];
  logic [WINDOW-1:0]    is_data;
  logic [WIN_CNT_W-1:0] seen;

  // Mark which window slots are data positions (not powers of two).
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      cand[i]    = base + POS_W'(i);
      is_data[i] = !((cand[i] != '0) && ((cand[i] & (cand[i] - POS_W'(1))) == '0));
    end
  end

  // This lane takes the (LANE+1)-th data slot of the window.
  always_comb begin
    seen = '0;
    pos  = base;
    for (int i = 0; i < WINDOW; i++) begin
      if (is_data[i]) begin
        seen = seen + WIN_CNT_W'(1);
        if (seen == WIN_CNT_W'(LANE + 1)) begin
          pos = cand[i];
        end
      end
    end
  end

  assign contrib = data_bit ? PARITY_WIDTH'(pos) : '0;

endmodule

>>> hdl/hps_merge.sv
// Merge stage: folds the lane contributions into the parity accumulator,
// advances the position past the byte and sizes the parity count.
// Depends on hps_pkg.
module hps_merge #(
  parameter int POS_W        = 12,
  parameter int BYTES_W      = 8,
  parameter int PARITY_WIDTH = hps_pkg::PARITY_WIDTH_DEF
) (
  input  logic [PARITY_WIDTH-1:0]     acc,
  input  logic [PARITY_WIDTH-1:0]     contrib [hps_pkg::BITS_PER_BYTE],
  input  logic [POS_W-1:0]            last_pos,
  input  logic [BYTES_W-1:0]          bytes_count,
  output logic [PARITY_WIDTH-1:0]     acc_sum,
  output logic [POS_W-1:0]            pos_after,
  output logic [hps_pkg::COUNT_W-1:0] count
);
  import hps_pkg::*;

  logic [COUNT_CALC_W-1:0] data_bits;
  logic [COUNT_CALC_W-1:0] span;
  logic [COUNT_CALC_W-1:0] need;

  always_comb begin
    acc_sum = acc;
    for (int k = 0; k < BITS_PER_BYTE; k++) begin
      acc_sum = acc_sum ^ contrib[k];
    end
  end

  assign pos_after = last_pos + POS_W'(1);

  // Smallest r >= 1 with 2^r >= m + r + 1; scanned downward so the
  // smallest passing r wins.
  assign data_bits = COUNT_CALC_W'(bytes_count) << 3;

  always_comb begin
    count = COUNT_W'(COUNT_MAX);
    span  = '0;
    need  = '0;
    for (int r = COUNT_MAX; r >= 1; r--) begin
      span = COUNT_CALC_W'(1) << r;
      need = data_bits + COUNT_CALC_W'(r) + COUNT_CALC_W'(1);
      if (span >= need) begin
        count = COUNT_W'(r);
      end
    end
  end

endmodule

>>> hdl/hamming_parity_syndrome.sv
// Hamming SEC parity generator and syndrome checker, top level.
// Depends on hps_pkg, hps_lane and hps_merge.
// The result is registered and appears on out_valid in the cycle after the byte
//   marked last is transferred. Throughput: one byte per cycle, sustained; in_ready
//   drops only while a finished result waits on a stalled output.
// Reset (rst, synchronous): position 3, counts and flags clear, no result pending.
module hamming_parity_syndrome #(
  parameter int MAX_BYTES    = hps_pkg::MAX_BYTES_DEF,
  parameter int PARITY_WIDTH = hps_pkg::PARITY_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [hps_pkg::MSG_W-1:0]          message_byte,
  input  logic                               last_byte,
  input  logic [hps_pkg::PARITY_FIELD_W-1:0] expected_parity,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hps_pkg::PARITY_FIELD_W-1:0] parity_bits,
  output logic [hps_pkg::COUNT_W-1:0]        parity_count,
  output logic [hps_pkg::PARITY_FIELD_W-1:0] error_position,
  output logic                               too_long
);
  import hps_pkg::*;

  // Position register is wide enough for the last byte's positions plus
  // the lane window and the parity slots skipped along the way.
  localparam int POS_W   = $clog2(BITS_PER_BYTE * MAX_BYTES + 32);
  localparam int BYTES_W = $clog2(MAX_BYTES + 1);

  // Message state
  logic [POS_W-1:0]        next_position;
  logic [PARITY_WIDTH-1:0] parity_accumulator;
  logic [BYTES_W-1:0]      bytes_taken;
  logic                    overflow_seen;

  // Lane outputs
  logic [POS_W-1:0]        lane_pos     [BITS_PER_BYTE];
  logic [PARITY_WIDTH-1:0] lane_contrib [BITS_PER_BYTE];

  // Merge outputs
  logic [PARITY_WIDTH-1:0] acc_sum;
  logic [POS_W-1:0]        pos_after;
  logic [COUNT_W-1:0]      count_new;

  logic                    accept;
  logic                    take;
  logic [BYTES_W-1:0]      bytes_next;
  logic [PARITY_WIDTH-1:0] acc_next;
  logic [POS_W-1:0]        pos_next;
  logic                    overflow_next;

  // The output register parts the two sides: a new byte is taken whenever
  // the held result is empty or leaving this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Bytes past the limit are dropped but flagged.
  assign take          = bytes_taken < BYTES_W'(MAX_BYTES);
  assign bytes_next    = take ? bytes_taken + BYTES_W'(1) : bytes_taken;
  assign acc_next      = take ? acc_sum : parity_accumulator;
  assign pos_next      = take ? pos_after : next_position;
  assign overflow_next = overflow_seen || !take;

  // Eight lanes, one per data bit; bit 0 lands first.
  for (genvar k = 0; k < BITS_PER_BYTE; k++) begin : g_lane
    hps_lane #(
      .LANE         (k),
      .POS_W        (POS_W),
      .PARITY_WIDTH (PARITY_WIDTH)
    ) u_lane (
      .base     (next_position),
      .data_bit (message_byte[k]),
      .pos      (lane_pos[k]),
      .contrib  (lane_contrib[k])
    );
  end

  hps_merge #(
    .POS_W        (POS_W),
    .BYTES_W      (BYTES_W),
    .PARITY_WIDTH (PARITY_WIDTH)
  ) u_merge (
    .acc         (parity_accumulator),
    .contrib     (lane_contrib),
    .last_pos    (lane_pos[BITS_PER_BYTE-1]),
    .bytes_count (bytes_next),
    .acc_sum     (acc_sum),
    .pos_after   (pos_after),
    .count       (count_new)
  );

  // Message state: advances per transfer, returns to start after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_position      <= POS_W'(FIRST_POS);
      parity_accumulator <= '0;
      bytes_taken        <= '0;
      overflow_seen      <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        next_position      <= POS_W'(FIRST_POS);
        parity_accumulator <= '0;
        bytes_taken        <= '0;
        overflow_seen      <= 1'b0;
      end else begin
        next_position      <= pos_next;
        parity_accumulator <= acc_next;
        bytes_taken        <= bytes_next;
        overflow_seen      <= overflow_next;
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; syndrome is parity XOR the expected word.
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      parity_bits    <= PARITY_FIELD_W'(acc_next);
      parity_count   <= count_new;
      error_position <= PARITY_FIELD_W'(acc_next) ^ expected_parity;
      too_long       <= overflow_next;
    end
  end

`ifndef ASSERT_OFF
  a_pos_floor: assert property (@(posedge clk) disable iff (rst)
    next_position >= POS_W'(FIRST_POS))
    else $error("position fell below first data slot");

  a_bytes_limit: assert property (@(posedge clk) disable iff (rst)
    bytes_taken <= BYTES_W'(MAX_BYTES))
    else $error("byte count beyond limit");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (bytes_taken == BYTES_W'(MAX_BYTES)))
    else $error("overflow flagged before limit reached");

  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (out_valid && (next_position == POS_W'(FIRST_POS))))
    else $error("last byte did not produce a result and restart");
`endif

endmodule

>>> verif/tb_hamming_parity_syndrome.sv
// Testbench for hamming_parity_syndrome: directed and random messages checked
// against an in-bench predictor of the Hamming parity word and syndrome.
// Depends on hps_pkg and the block's RTL; the block itself stays a black box.
module tb_hamming_parity_syndrome;
  import hps_pkg::*;

  localparam int MAX_BYTES    = MAX_BYTES_DEF;
  localparam int PARITY_WIDTH = PARITY_WIDTH_DEF;
  localparam int RANDOM_BYTES = 1500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;   // receiver hold-off that backs up the block
  localparam int HOLD_AFTER   = 20;    // results seen before the long hold starts

  // How the bytes of a generated message are filled.
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ALT} fill_t;
  // How expected_parity is chosen on the last byte.
  typedef enum int {EXP_RANDOM, EXP_MATCH, EXP_FLIP, EXP_ALL_ONES} expect_t;

  // Running state of one message: next codeword position, parity XOR,
  // bytes placed and whether a byte was dropped for length.
  typedef struct packed {
    logic [15:0]             pos;
    logic [PARITY_WIDTH-1:0] acc;
    logic [8:0]              taken;
    logic                    ovf;
  } msg_state_t;

  localparam msg_state_t MSG_IDLE = '{pos: 16'(FIRST_POS), acc: '0, taken: '0, ovf: 1'b0};

  typedef struct packed {
    logic [MSG_W-1:0]          data;
    logic                      last;
    logic [PARITY_FIELD_W-1:0] expected;
    logic [2:0]                gap;    // idle cycles before this byte is offered
  } tx_byte_t;

  typedef struct packed {
    logic [PARITY_FIELD_W-1:0] parity_bits;
    logic [COUNT_W-1:0]        parity_count;
    logic [PARITY_FIELD_W-1:0] error_position;
    logic                      too_long;
  } parity_report_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [MSG_W-1:0]          message_byte = '0;
  logic                      last_byte = 1'b0;
  logic [PARITY_FIELD_W-1:0] expected_parity = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [PARITY_FIELD_W-1:0] parity_bits;
  logic [COUNT_W-1:0]        parity_count;
  logic [PARITY_FIELD_W-1:0] error_position;
  logic                      too_long;

  hamming_parity_syndrome #(
    .MAX_BYTES   (MAX_BYTES),
    .PARITY_WIDTH(PARITY_WIDTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .message_byte   (message_byte),
    .last_byte      (last_byte),
    .expected_parity(expected_parity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .parity_bits    (parity_bits),
    .parity_count   (parity_count),
    .error_position (error_position),
    .too_long       (too_long)
  );

  tx_byte_t       byte_backlog[$];   // bytes waiting for the driver
  parity_report_t owed_reports[$];   // predicted results, oldest first
  msg_state_t     tracked_msg = MSG_IDLE;
  bit             in_xfer = 1'b0;    // transfer seen at the last rising edge
  bit             out_xfer = 1'b0;
  int             results_seen = 0;
  int             error_count = 0;
  int             cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Place one byte, LSB first, into the next eight positions that are not
  // powers of two. Once the length cap is hit the byte is dropped and flagged.
  function automatic void absorb_byte(inout msg_state_t s, input logic [MSG_W-1:0] b);
    if (s.taken < MAX_BYTES) begin
      for (int k = 0; k < BITS_PER_BYTE; k++) begin
        while (s.pos != 0 && (s.pos & (s.pos - 16'd1)) == 0)
          s.pos++;
        if (b[k])
          s.acc = s.acc ^ s.pos[PARITY_WIDTH-1:0];
        s.pos++;
      end
      s.taken++;
    end else begin
      s.ovf = 1'b1;
    end
  endfunction

  // Queue up one message. The parity is tracked here as well so that the
  // last byte can carry a matching, single-bit-off or arbitrary reference.
  task automatic add_message(input int len, input fill_t fill, input expect_t sel,
                             input bit no_idle);
    msg_state_t       s;
    tx_byte_t         t;
    logic [MSG_W-1:0] b;
    s = MSG_IDLE;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = '0;
        FILL_ONES: b = '1;
        FILL_ALT:  b = i[0] ? 8'hAA : 8'h55;
        default:   b = MSG_W'($urandom);
      endcase
      absorb_byte(s, b);
      t.data     = b;
      t.last     = (i == len - 1);
      t.gap      = no_idle ? 3'd0 : 3'($urandom_range(0, 7));
      t.expected = PARITY_FIELD_W'($urandom);
      if (t.last) begin
        case (sel)
          EXP_MATCH:    t.expected = PARITY_FIELD_W'(s.acc);
          EXP_FLIP:     t.expected = PARITY_FIELD_W'(s.acc) ^
                                     (PARITY_FIELD_W'(1) << $urandom_range(0, PARITY_FIELD_W - 1));
          EXP_ALL_ONES: t.expected = '1;
          default:      ;
        endcase
      end
      byte_backlog.push_back(t);
    end
  endtask

  // Monitor: samples both channels at the rising edge, predicts on each input
  // transfer and checks each output transfer against the oldest prediction.
  always @(posedge clk) begin : monitor_p
    parity_report_t want;
    int             r;
    int             m;
    in_xfer  = 1'b0;
    out_xfer = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_xfer = 1'b1;
        absorb_byte(tracked_msg, message_byte);
        if (last_byte) begin
          // Smallest r with 2^r >= m + r + 1, m data bits actually placed.
          m = int'(tracked_msg.taken) * BITS_PER_BYTE;
          r = 1;
          while (r < 40 && (64'd1 << r) < 64'(m + r + 1))
            r++;
          want.parity_bits    = PARITY_FIELD_W'(tracked_msg.acc);
          want.parity_count   = COUNT_W'(r);
          want.error_position = PARITY_FIELD_W'(tracked_msg.acc) ^ expected_parity;
          want.too_long       = tracked_msg.ovf;
          owed_reports.push_back(want);
          tracked_msg = MSG_IDLE;   // next message starts from scratch
        end
      end
      if (out_valid && out_ready) begin
        out_xfer = 1'b1;
        results_seen++;
        if (owed_reports.size() == 0) begin
          $error("result transfer with nothing expected");
          error_count++;
        end else begin
          want = owed_reports.pop_front();
          if (parity_bits !== want.parity_bits) begin
            $error("parity_bits: expected %0d, actual %0d", want.parity_bits, parity_bits);
            error_count++;
          end
          if (parity_count !== want.parity_count) begin
            $error("parity_count: expected %0d, actual %0d", want.parity_count, parity_count);
            error_count++;
          end
          if (error_position !== want.error_position) begin
            $error("error_position: expected %0d, actual %0d",
                   want.error_position, error_position);
            error_count++;
          end
          if (too_long !== want.too_long) begin
            $error("too_long: expected %0d, actual %0d", want.too_long, too_long);
            error_count++;
          end
        end
      end
    end
  end

  // Driver: offers bytes at the falling edge. A byte stays up until its
  // transfer; the next one waits out its own drawn gap first.
  always @(negedge clk) begin : driver_p
    tx_byte_t t;
    static int wait_count = 0;
    if (!rst && (!in_valid || in_xfer)) begin
      if (byte_backlog.size() > 0 && wait_count < int'(byte_backlog[0].gap)) begin
        wait_count++;
        in_valid <= 1'b0;
      end else if (byte_backlog.size() > 0) begin
        t = byte_backlog.pop_front();
        message_byte    <= t.data;
        last_byte       <= t.last;
        expected_parity <= t.expected;
        in_valid        <= 1'b1;
        wait_count = 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a fresh stall of random length after every result transfer, with
  // stall-free stretches, and one long hold-off so the block fills and
  // pushes back on the sender.
  always @(negedge clk) begin : receiver_p
    static int stall_left = 0;
    static int hold_left  = 0;
    static bit hold_done  = 1'b0;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_xfer)
        stall_left = ((results_seen / 16) % 4 == 3) ? 0 : $urandom_range(0, 7);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin : watchdog_p
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : sequence_p
    int    random_bytes;
    int    len;
    int    pick;
    fill_t fill;
    random_bytes = 0;

    // Directed: all-zero and all-one single bytes, matching and off-by-one
    // references, an alternating pattern, and a message past the length cap
    // whose last byte is itself one of the dropped ones.
    add_message(1, FILL_ZERO, EXP_MATCH, 1'b0);
    add_message(1, FILL_ONES, EXP_ALL_ONES, 1'b0);
    add_message(1, FILL_ONES, EXP_FLIP, 1'b1);
    add_message(2, FILL_ALT, EXP_RANDOM, 1'b0);
    add_message(3, FILL_RANDOM, EXP_MATCH, 1'b0);
    add_message(MAX_BYTES + 2, FILL_ONES, EXP_FLIP, 1'b1);
    add_message(1, FILL_RANDOM, EXP_RANDOM, 1'b0);   // state must be back to idle

    // Random: mostly short messages, a few near or past the cap.
    while (random_bytes < RANDOM_BYTES) begin
      len  = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_BYTES - 28, MAX_BYTES + 8)
                                          : $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES :
             (pick == 2) ? FILL_ALT : FILL_RANDOM;
      add_message(len, fill, expect_t'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
      random_bytes += len;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every byte transferred, every result back, then a short margin.
    while (byte_backlog.size() != 0 || in_valid)
      @(posedge clk);
    while (owed_reports.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
hdl/hps_pkg.sv
hdl/hps_lane.sv
hdl/hps_merge.sv
hdl/hamming_parity_syndrome.sv
verif/tb_hamming_parity_syndrome.sv
